// ===== hdl/mrc_pkg.sv =====
package mrc_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;
  typedef logic [6:0]  flen_t;

  localparam int STATUS_REGS_DEF = 7;
  localparam int MAX_FRAME_DEF   = 64;

  // status register slots that feed the latched outputs
  localparam int LATCH_N = 7;

  localparam word_t CRC_POLY = 16'hA001;
  localparam word_t CRC_INIT = 16'hFFFF;

  localparam byte_t SLAVE_ADDR_RST   = 8'd1;
  localparam byte_t PRIVATE_HEAD_RST = 8'd170;
  localparam byte_t WRITE_FUNC_RST   = 8'd6;
  localparam word_t STATUS_BASE_RST  = 16'h2000;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAVE_ADDR   = 2'd0,
    CFG_PRIVATE_HEAD = 2'd1,
    CFG_WRITE_FUNC   = 2'd2,
    CFG_STATUS_BASE  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_ARM  = 1'b0,
    CMD_BYTE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_PRIVATE    = 3'd0,
    KIND_WRITE_ECHO = 3'd1,
    KIND_CONFIG     = 3'd2,
    KIND_STATUS     = 3'd3,
    KIND_FOREIGN    = 3'd4
  } frame_kind_e;

  typedef struct packed {
    byte_t slave_address;
    byte_t private_head;
    byte_t write_function;
    word_t status_base;
  } cfg_t;

  typedef struct packed {
    logic  cmd;
    word_t listen_reg;
    flen_t frame_len;
    byte_t rx_byte;
  } item_t;

  typedef struct packed {
    frame_kind_e frame_kind;
    logic        crc_error;
    logic        link_alive;
    word_t       work_status;
    word_t       run_speed;
    word_t       bus_voltage;
    word_t       motor_current;
    word_t       fault_code;
    word_t       driver_temp;
  } result_t;

  // CRC-16/MODBUS over one byte, reflected form
  function automatic word_t crc_byte(input word_t c, input byte_t b);
    word_t x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// ===== hdl/mrc_in_if.sv =====
interface mrc_in_if;
  import mrc_pkg::*;

  logic  valid;
  logic  ready;
  logic  cmd;
  word_t listen_reg;
  flen_t frame_len;
  byte_t rx_byte;

  modport source (output valid, output cmd, output listen_reg, output frame_len,
                  output rx_byte, input ready);
  modport sink   (input valid, input cmd, input listen_reg, input frame_len,
                  input rx_byte, output ready);
endinterface

// ===== hdl/mrc_out_if.sv =====
interface mrc_out_if;
  import mrc_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] frame_kind;
  logic       crc_error;
  logic       link_alive;
  word_t      work_status;
  word_t      run_speed;
  word_t      bus_voltage;
  word_t      motor_current;
  word_t      fault_code;
  word_t      driver_temp;

  modport source (output valid, output frame_kind, output crc_error, output link_alive,
                  output work_status, output run_speed, output bus_voltage,
                  output motor_current, output fault_code, output driver_temp,
                  input ready);
  modport sink   (input valid, input frame_kind, input crc_error, input link_alive,
                  input work_status, input run_speed, input bus_voltage,
                  input motor_current, input fault_code, input driver_temp,
                  output ready);
endinterface

// ===== hdl/mrc_in_reg.sv =====
module mrc_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  mrc_in_if.sink        in_i,
  input  logic          advance_i,
  output logic          item_valid_o,
  output mrc_pkg::item_t item_o
);
  import mrc_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  take;

  // take a new transaction whenever the register is empty or the held one moves on this cycle
  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.cmd        <= in_i.cmd;
      item_q.listen_reg <= in_i.listen_reg;
      item_q.frame_len  <= in_i.frame_len;
      item_q.rx_byte    <= in_i.rx_byte;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== hdl/mrc_core.sv =====
module mrc_core #(
  parameter int STATUS_REGS = mrc_pkg::STATUS_REGS_DEF,
  parameter int MAX_FRAME   = mrc_pkg::MAX_FRAME_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mrc_pkg::cfg_t    cfg_i,
  input  logic             item_valid_i,
  input  mrc_pkg::item_t   item_i,
  input  logic             advance_i,
  output logic             res_valid_o,
  output mrc_pkg::result_t res_o
);
  import mrc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_FRAME + 1);
  localparam int WIDE_W = (CNT_W > 9) ? CNT_W + 1 : 10;
  localparam int SLOT_W = 17;

  // frame state
  word_t            awaited_reg_q;
  logic [CNT_W-1:0] awaited_len_q;
  logic [CNT_W-1:0] byte_index_q;
  word_t            crc_q;
  byte_t            head_q [3];
  byte_t            crc_low_q;
  byte_t            high_hold_q;
  word_t            shadow_q [STATUS_REGS];
  word_t            status_q [STATUS_REGS];
  word_t            status_d [STATUS_REGS];
  word_t            lat      [LATCH_N];

  logic              go, arm_go, byte_go, listening;
  byte_t             b, h0, h1, h2;
  logic [WIDE_W-1:0] pos_w, len_w, end_w, chk_w, bc_w, max_w, fl_w, len_clamp, d_w;
  logic [CNT_W-1:0]  next_idx;
  frame_kind_e       kind;
  logic              pending, too_big, chk_kind, crc_step, low_take, data_take;
  logic              done, cerr, alive, commit;
  word_t             crc_next, got, start;
  logic [SLOT_W-1:0] start_x, slot, n_x;
  logic [STATUS_REGS-1:0] in_win;

  assign go        = advance_i && item_valid_i;
  assign arm_go    = go && (item_i.cmd == CMD_ARM);
  assign listening = (awaited_len_q != '0);
  assign byte_go   = go && (item_i.cmd == CMD_BYTE) && listening;
  assign b         = item_i.rx_byte;

  assign pos_w = WIDE_W'(byte_index_q);
  assign len_w = WIDE_W'(awaited_len_q);
  assign max_w = WIDE_W'(MAX_FRAME);
  assign fl_w  = WIDE_W'(item_i.frame_len);
  assign len_clamp = (fl_w > max_w) ? max_w : fl_w;

  // head bytes as they stand after this byte
  assign h0   = (pos_w == WIDE_W'(0)) ? b : head_q[0];
  assign h1   = (pos_w == WIDE_W'(1)) ? b : head_q[1];
  assign h2   = (pos_w == WIDE_W'(2)) ? b : head_q[2];
  assign bc_w = WIDE_W'(h2);

  always_comb begin
    kind    = KIND_FOREIGN;
    end_w   = '0;
    chk_w   = '0;
    pending = 1'b0;
    too_big = 1'b0;
    if (h0 == cfg_i.private_head) begin
      kind  = KIND_PRIVATE;
      end_w = len_w;
    end else if (h0 != cfg_i.slave_address) begin
      kind  = KIND_FOREIGN;
      end_w = len_w;
    end else if (pos_w == WIDE_W'(0)) begin
      kind    = KIND_CONFIG;
      pending = 1'b1;
    end else if (h1 == cfg_i.write_function) begin
      kind  = KIND_WRITE_ECHO;
      end_w = WIDE_W'(8);
      chk_w = WIDE_W'(6);
    end else if (awaited_reg_q < cfg_i.status_base) begin
      kind  = KIND_CONFIG;
      end_w = (len_w < WIDE_W'(2)) ? WIDE_W'(2) : len_w;
    end else begin
      kind = KIND_STATUS;
      if (pos_w < WIDE_W'(2)) begin
        pending = 1'b1;
      end else begin
        chk_w   = bc_w + WIDE_W'(3);
        end_w   = bc_w + WIDE_W'(5);
        too_big = (end_w > max_w);
      end
    end
  end

  assign chk_kind  = (kind == KIND_WRITE_ECHO) || (kind == KIND_STATUS);
  assign crc_step  = pending || (chk_kind && (pos_w < chk_w));
  assign low_take  = chk_kind && !pending && (pos_w == chk_w);
  assign data_take = (kind == KIND_STATUS) && !pending && !too_big &&
                     (pos_w >= WIDE_W'(3)) && (pos_w < bc_w + WIDE_W'(3));
  assign d_w       = pos_w - WIDE_W'(3);

  assign start   = awaited_reg_q - cfg_i.status_base;
  assign start_x = SLOT_W'(start);
  assign slot    = start_x + SLOT_W'(d_w >> 1);
  assign n_x     = SLOT_W'(h2 >> 1);

  assign crc_next = crc_step ? crc_byte(crc_q, b) : crc_q;
  assign got      = {b, crc_low_q};
  assign next_idx = byte_index_q + CNT_W'(1);
  assign done     = !pending && (too_big || (WIDE_W'(next_idx) == end_w));
  assign cerr     = chk_kind && (too_big || (got != crc_next));
  assign alive    = chk_kind ? !cerr : (kind != KIND_FOREIGN);
  assign commit   = byte_go && done && (kind == KIND_STATUS) && alive;

  // commit window over the status registers
  always_comb begin
    for (int i = 0; i < STATUS_REGS; i++) begin
      in_win[i]   = (SLOT_W'(i) >= start_x) && ((SLOT_W'(i) - start_x) < n_x);
      status_d[i] = (commit && in_win[i]) ? shadow_q[i] : status_q[i];
    end
  end

  for (genvar g = 0; g < LATCH_N; g++) begin : g_lat
    if (g < STATUS_REGS) begin : g_on
      assign lat[g] = status_d[g];
    end else begin : g_off
      assign lat[g] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_reg_q <= '0;
      awaited_len_q <= '0;
      byte_index_q  <= '0;
      crc_q         <= CRC_INIT;
      for (int i = 0; i < STATUS_REGS; i++) begin
        status_q[i] <= '0;
      end
    end else if (arm_go) begin
      awaited_reg_q <= item_i.listen_reg;
      awaited_len_q <= len_clamp[CNT_W-1:0];
      byte_index_q  <= '0;
      crc_q         <= CRC_INIT;
    end else if (byte_go) begin
      status_q <= status_d;
      if (done) begin
        byte_index_q <= '0;
        crc_q        <= CRC_INIT;
        if (!cerr) begin
          // accepted or foreign: stop listening
          awaited_reg_q <= '0;
          awaited_len_q <= '0;
        end
      end else begin
        byte_index_q <= next_idx;
        crc_q        <= crc_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_go) begin
      for (int i = 0; i < 3; i++) begin
        if (pos_w == WIDE_W'(i)) begin
          head_q[i] <= b;
        end
      end
      if (low_take) begin
        crc_low_q <= b;
      end
      if (data_take && !d_w[0]) begin
        high_hold_q <= b;
      end
      for (int i = 0; i < STATUS_REGS; i++) begin
        if (data_take && d_w[0] && (slot == SLOT_W'(i))) begin
          shadow_q[i] <= {high_hold_q, b};
        end
      end
    end
  end

  assign res_valid_o         = byte_go && done;
  assign res_o.frame_kind    = kind;
  assign res_o.crc_error     = cerr;
  assign res_o.link_alive    = alive;
  assign res_o.work_status   = lat[0];
  assign res_o.run_speed     = lat[1];
  assign res_o.bus_voltage   = lat[3];
  assign res_o.motor_current = lat[4];
  assign res_o.fault_code    = lat[5];
  assign res_o.driver_temp   = lat[6];

endmodule

// ===== hdl/mrc_out_reg.sv =====
module mrc_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  mrc_pkg::result_t res_i,
  output logic             space_o,
  mrc_out_if.source        res_o
);
  import mrc_pkg::*;

  logic    valid_q;
  result_t res_q;

  // room when empty or when the held transaction leaves this cycle
  assign space_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.frame_kind    = res_q.frame_kind;
  assign res_o.crc_error     = res_q.crc_error;
  assign res_o.link_alive    = res_q.link_alive;
  assign res_o.work_status   = res_q.work_status;
  assign res_o.run_speed     = res_q.run_speed;
  assign res_o.bus_voltage   = res_q.bus_voltage;
  assign res_o.motor_current = res_q.motor_current;
  assign res_o.fault_code    = res_q.fault_code;
  assign res_o.driver_temp   = res_q.driver_temp;

endmodule

// ===== hdl/modbus_rtu_reply_checker.sv =====
// A byte transaction that closes a frame is loaded into the input register on acceptance;
// its result then goes into the result register when the output is not stalled.
// Throughput: one transaction per cycle while the output is not stalled; the whole CRC
// step and frame decode sit between the input register and the result register.
// Reset (rst_ni, async, active low): not listening, CRC at 0xFFFF, status registers
// zero, configuration registers at their defaults, both stages empty.
module modbus_rtu_reply_checker #(
  parameter int STATUS_REGS = mrc_pkg::STATUS_REGS_DEF,
  parameter int MAX_FRAME   = mrc_pkg::MAX_FRAME_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mrc_in_if.sink                          in_i,
  mrc_out_if.source                       res_o,
  input  logic                            cfg_we_i,
  input  logic [mrc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  mrc_pkg::word_t                  cfg_data_i
);
  import mrc_pkg::*;

  cfg_t    cfg_q;
  logic    item_valid, advance, space, res_valid;
  item_t   item;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_address  <= SLAVE_ADDR_RST;
      cfg_q.private_head   <= PRIVATE_HEAD_RST;
      cfg_q.write_function <= WRITE_FUNC_RST;
      cfg_q.status_base    <= STATUS_BASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SLAVE_ADDR:   cfg_q.slave_address  <= cfg_data_i[7:0];
        CFG_PRIVATE_HEAD: cfg_q.private_head   <= cfg_data_i[7:0];
        CFG_WRITE_FUNC:   cfg_q.write_function <= cfg_data_i[7:0];
        CFG_STATUS_BASE:  cfg_q.status_base    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance = item_valid && space;

  mrc_in_reg u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  mrc_core #(
    .STATUS_REGS (STATUS_REGS),
    .MAX_FRAME   (MAX_FRAME)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .advance_i    (advance),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  mrc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .space_o     (space),
    .res_o       (res_o)
  );

endmodule

// ===== hdl/mrc_checker.sv =====
module mrc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic [2:0] frame_kind_i,
  input logic       crc_error_i,
  input logic       link_alive_i
);
  import mrc_pkg::*;

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(frame_kind_i) && $stable(crc_error_i)
                            && $stable(link_alive_i))
    else $error("stalled result changed");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> !(crc_error_i && link_alive_i))
    else $error("crc error and link alive together");

  a_foreign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (frame_kind_i == KIND_FOREIGN) |-> !link_alive_i && !crc_error_i)
    else $error("foreign frame flagged");

  a_nocheck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ((frame_kind_i == KIND_PRIVATE) || (frame_kind_i == KIND_CONFIG))
    |-> link_alive_i && !crc_error_i)
    else $error("unchecked frame not accepted");

endmodule

bind modbus_rtu_reply_checker mrc_checker u_mrc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_i      (res_o.valid),
  .ready_i      (res_o.ready),
  .frame_kind_i (res_o.frame_kind),
  .crc_error_i  (res_o.crc_error),
  .link_alive_i (res_o.link_alive)
);
